/* hdl/pu_pkg.sv */
// ----------------------------------------------------------------------------
// pu_pkg: shared types, constants and the factorial table
// Widths and shared structures of the permutation unranking block.
// ----------------------------------------------------------------------------
package pu_pkg;

  // Largest number of values permuted
  localparam int PERM_MAX = 13;

  // Field widths
  localparam int LEN_W    = 4;
  localparam int OFFS_W   = 20;
  localparam int RANK_W   = 33;
  localparam int ELEM_W   = 21;
  localparam int CFG_W    = 20;
  localparam int CIDX_W   = 1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PERM_LENGTH  = 1'b0;
  localparam logic [CIDX_W-1:0] REG_VALUE_OFFSET = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Settled configuration seen by both halves
  typedef struct packed {
    logic [LEN_W-1:0]  len;     // effective length, saturated to PERM_MAX
    logic [OFFS_W-1:0] offset;
  } cfg_t;

  // One classified rank waiting for the walk
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              err;
  } item_t;

  // Factorial table, 0! .. 13!
  function automatic logic [RANK_W-1:0] fact(input logic [LEN_W-1:0] idx);
    logic [RANK_W-1:0] f;
    case (idx)
      4'd0:    f = 33'd1;
      4'd1:    f = 33'd1;
      4'd2:    f = 33'd2;
      4'd3:    f = 33'd6;
      4'd4:    f = 33'd24;
      4'd5:    f = 33'd120;
      4'd6:    f = 33'd720;
      4'd7:    f = 33'd5040;
      4'd8:    f = 33'd40320;
      4'd9:    f = 33'd362880;
      4'd10:   f = 33'd3628800;
      4'd11:   f = 33'd39916800;
      4'd12:   f = 33'd479001600;
      4'd13:   f = 33'd6227020800;
      default: f = '1;
    endcase
    return f;
  endfunction

  // Lowest set bit of a value mask; found flag in the top bit
  function automatic logic [LEN_W:0] lowest_set(input logic [PERM_MAX-1:0] m);
    logic [LEN_W:0] r;
    r = '0;
    for (int i = PERM_MAX - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, LEN_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

/* hdl/pu_front.sv */
// ----------------------------------------------------------------------------
// pu_front: configuration registers and rank classification
// Holds the two configuration registers, checks each incoming rank against
// the length's factorial and pushes the classified rank into the queue.
// ----------------------------------------------------------------------------
module pu_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  input  logic                       cfg_wr_en,
  input  logic [pu_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [pu_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                       q_full,
  output logic                       q_push,
  output pu_pkg::item_t              q_item,
  output pu_pkg::cfg_t               cfg
);

  logic [pu_pkg::LEN_W-1:0]  perm_length_r;
  logic [pu_pkg::OFFS_W-1:0] value_offset_r;
  logic [pu_pkg::LEN_W-1:0]  len_eff;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_length_r  <= pu_pkg::LEN_W'(pu_pkg::PERM_MAX);
      value_offset_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pu_pkg::REG_PERM_LENGTH:  perm_length_r  <= cfg_wr_data[pu_pkg::LEN_W-1:0];
        pu_pkg::REG_VALUE_OFFSET: value_offset_r <= cfg_wr_data[pu_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the length
  assign len_eff = (perm_length_r > pu_pkg::LEN_W'(pu_pkg::PERM_MAX)) ?
                   pu_pkg::LEN_W'(pu_pkg::PERM_MAX) : perm_length_r;

  assign cfg.len    = len_eff;
  assign cfg.offset = value_offset_r;

  // Classify and push
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.rank = in_rank;
  assign q_item.err  = (len_eff == '0) || (in_rank == '0) ||
                       (in_rank > pu_pkg::fact(len_eff));

endmodule

/* hdl/pu_queue.sv */
// ----------------------------------------------------------------------------
// pu_queue: two-entry FIFO between front and back
// Lets the front take a new rank while the back is still walking one.
// ----------------------------------------------------------------------------
module pu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pu_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pu_pkg::item_t head_item
);

  pu_pkg::item_t               entry_r [pu_pkg::QUEUE_DEPTH];
  logic [pu_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [pu_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [pu_pkg::QCNT_W-1:0]   cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (cnt_r == pu_pkg::QCNT_W'(pu_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/pu_back.sv */
// ----------------------------------------------------------------------------
// pu_back: compare-subtract walk and result register
// Walks the unused values of each rank one per cycle (stalls hold a found
// value), subtracting the factorial of the remaining count until it covers
// the rank, and emits one element per position through the output register.
// ----------------------------------------------------------------------------
module pu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pu_pkg::cfg_t               cfg,
  input  logic                       q_valid,
  input  pu_pkg::item_t              q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pu_pkg::ELEM_W-1:0]  out_element,
  output logic                       out_last,
  output logic                       out_rank_error
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                         state_r, state_nxt;
  logic [pu_pkg::RANK_W-1:0]    rem_r, rem_nxt;
  logic [pu_pkg::PERM_MAX-1:0]  used_r, used_nxt;
  logic [pu_pkg::LEN_W-1:0]     pos_r, pos_nxt;
  logic [pu_pkg::LEN_W-1:0]     v_r, v_nxt;
  logic                         err_r, err_nxt;

  logic                         out_valid_r;
  logic [pu_pkg::ELEM_W-1:0]    out_element_r;
  logic                         out_last_r;
  logic                         out_rank_error_r;

  logic                         out_free;
  logic                         emit;
  logic [pu_pkg::ELEM_W-1:0]    emit_elem;
  logic                         emit_last;
  logic                         emit_err;

  logic [pu_pkg::PERM_MAX-1:0]  len_mask;
  logic [pu_pkg::PERM_MAX-1:0]  free_above;
  logic [pu_pkg::PERM_MAX-1:0]  used_pick;
  logic [pu_pkg::LEN_W:0]       above_hit;
  logic [pu_pkg::LEN_W:0]       first_hit;
  logic [pu_pkg::RANK_W-1:0]    step_fact;
  logic                         is_last;

  // Walk helpers
  assign len_mask   = (pu_pkg::PERM_MAX'(1) << cfg.len) - pu_pkg::PERM_MAX'(1);
  assign free_above = ~used_r & len_mask &
                      ~((pu_pkg::PERM_MAX'(2) << v_r) - pu_pkg::PERM_MAX'(1));
  assign above_hit  = pu_pkg::lowest_set(free_above);
  assign used_pick  = used_r | (pu_pkg::PERM_MAX'(1) << v_r);
  assign first_hit  = pu_pkg::lowest_set(~used_pick & len_mask);
  assign step_fact  = pu_pkg::fact(cfg.len - pos_r - pu_pkg::LEN_W'(1));
  assign is_last    = ((pos_r + pu_pkg::LEN_W'(1)) == cfg.len);
  assign out_free   = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    used_nxt  = used_r;
    pos_nxt   = pos_r;
    v_nxt     = v_r;
    err_nxt   = err_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_elem = '0;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rem_nxt   = q_item.rank;
          err_nxt   = q_item.err;
          used_nxt  = '0;
          pos_nxt   = '0;
          v_nxt     = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (err_r) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_err  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (step_fact >= rem_r || !above_hit[pu_pkg::LEN_W]) begin
          // Value found (or no unused value left): emit it
          if (out_free) begin
            emit      = 1'b1;
            emit_elem = pu_pkg::ELEM_W'(cfg.offset) + pu_pkg::ELEM_W'(v_r) +
                        pu_pkg::ELEM_W'(1);
            emit_last = is_last;
            used_nxt  = used_pick;
            pos_nxt   = pos_r + pu_pkg::LEN_W'(1);
            v_nxt     = first_hit[pu_pkg::LEN_W-1:0];
            if (is_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          // Skip this value
          rem_nxt = rem_r - step_fact;
          v_nxt   = above_hit[pu_pkg::LEN_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    used_r <= used_nxt;
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    err_r  <= err_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_element_r    <= emit_elem;
      out_last_r       <= emit_last;
      out_rank_error_r <= emit_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_element    = out_element_r;
  assign out_last       = out_last_r;
  assign out_rank_error = out_rank_error_r;

  // Checks
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rank_error_r |-> out_last_r)
    else $error("error beat not marked last");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !err_r |-> pos_r < cfg.len)
    else $error("position past length during walk");

  a_cursor_unused: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !err_r |-> !used_r[v_r])
    else $error("walk cursor on a used value");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_last |=> state_r == ST_IDLE)
    else $error("walk continues after last element");

endmodule

/* hdl/permutation_unrank.sv */
// ----------------------------------------------------------------------------
// permutation_unrank: k-th lexicographic permutation by factorial unranking
// Takes a one-based rank and emits the permutation of value_offset+1 ..
// value_offset+perm_length one element per beat, last element marked.
// ----------------------------------------------------------------------------
// A rank leaves the queue in the idle state; the back end then emits each
// element and skips each unused value in turn, all through the single
// factorial compare-subtract unit of the back end. An invalid rank (zero,
// above perm_length!, or length zero) gives one beat with element 0, last
// and rank_error set. A two-entry queue lets up to two further ranks be
// accepted while a walk runs.
module permutation_unrank (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pu_pkg::ELEM_W-1:0]  out_element,
  output logic                       out_last,
  output logic                       out_rank_error,
  input  logic                       cfg_wr_en,
  input  logic [pu_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [pu_pkg::CFG_W-1:0]   cfg_wr_data
);

  pu_pkg::cfg_t  cfg;
  pu_pkg::item_t push_item;
  pu_pkg::item_t head_item;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;

  pu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rank     (in_rank),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item),
    .cfg         (cfg)
  );

  pu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  pu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_element    (out_element),
    .out_last       (out_last),
    .out_rank_error (out_rank_error)
  );

endmodule
